@@ hdl/ncap_pkg.sv @@
// Package for the NMEA sentence capture unit: item types, controller state,
// command and status structs, character codes and sentence tags.
// No dependencies; compile this file first.
`default_nettype none

package ncap_pkg;

	// Default line buffer size in bytes; one byte position is never filled.
	localparam int unsigned SENTENCE_BYTES_DEF = 128;

	// Action codes of an input transaction. Code 3 has no meaning and changes nothing.
	localparam logic [1:0] ACT_RX    = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// Store selectors.
	localparam logic SEL_GGA = 1'b0;
	localparam logic SEL_GLL = 1'b1;

	// Character codes.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// Sentence tags, first character in the top byte.
	localparam int unsigned TAG_LEN = 6;
	localparam logic [8*TAG_LEN-1:0] GGA_TAG = "$GNGGA";
	localparam logic [8*TAG_LEN-1:0] GLL_TAG = "$GNGLL";

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
		logic       which_sentence;
		logic [6:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic [6:0] read_length;
		logic       gga_updated;
		logic       gll_updated;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_COPY = 4'b0010,
		ST_READ = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic take;      // input transaction accepted this cycle
		logic copy;      // line buffer to store copy in progress
		logic load_out;  // capture the result into the output register
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic copy_start; // the offered item ends a line with a known tag
		logic copy_done;  // last copy cycle
	} sts_t;

endpackage

`default_nettype wire

@@ hdl/ncap_stream_if.sv @@
// Valid/ready stream interface used for the request and response channels.
// Payload type is a parameter; depends on nothing else.
`default_nettype none

interface ncap_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/nmea_sentence_capture_unit.sv @@
// NMEA sentence capture unit, top level. Joins the controller and the datapath.
// Depends on ncap_pkg, ncap_stream_if, ncap_ram, ncap_ctrl and ncap_datapath.
//
// This block watches a stream of received serial bytes and keeps the latest
// $GNGGA and $GNGLL sentences. Each request transaction carries an action:
// a received byte, a read of one stored character, or a clear of an update
// flag. Every request yields exactly one response transaction holding the
// selected stored character (zero at or past the stored length), the stored
// length and both update flags, all as they stand after the request took
// effect. One request is handled at a time. From acceptance to a loaded
// response a request goes through accepting and updating the line state,
// the registered store read and the capture of the result.
// A byte that ends a line carrying a known tag also runs the copy engine,
// which moves one character per cycle from the line buffer RAM into the
// store RAM, a rate set by the single read port of the line buffer.
// A finished response waits in its output register; meanwhile the next request
// is accepted, and its result is captured only once the waiting response has
// been taken or is being taken.
// There is no clearing pass after reset; stores are never read before they
// are written because reads past the stored length return zero.
`default_nettype none

module nmea_sentence_capture_unit #(
	parameter int unsigned SENTENCE_BYTES = ncap_pkg::SENTENCE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ncap_stream_if.sink   request,
	ncap_stream_if.source response
);
	import ncap_pkg::*;

	// Command and status between the controller and the datapath.
	cmd_t cmd;
	sts_t sts;

	logic req_ready;
	logic rsp_valid;

	// The controller owns both handshakes and sequences accept, copy, read
	// and result capture.
	ncap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (response.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the line buffer, the two sentence stores, lengths,
	// flags and the response payload register.
	ncap_datapath #(
		.SENTENCE_BYTES (SENTENCE_BYTES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (request.data),
		.cmd    (cmd),
		.sts    (sts),
		.result (response.data)
	);

	assign request.ready  = req_ready;
	assign response.valid = rsp_valid;
endmodule

`default_nettype wire

@@ hdl/ncap_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module ncap_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

@@ hdl/ncap_ctrl.sv @@
// Controller state machine of the NMEA sentence capture unit.
// Depends on ncap_pkg.
`default_nettype none

module ncap_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	output logic         rsp_valid,
	input  logic         rsp_ready,
	input  ncap_pkg::sts_t sts,
	output ncap_pkg::cmd_t cmd
);
	import ncap_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	assign cmd.take     = req_valid && req_ready;
	assign cmd.copy     = (state_q == ST_COPY);
	assign cmd.load_out = (state_q == ST_DONE) && rsp_free;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take) begin
					state_next = sts.copy_start ? ST_COPY : ST_READ;
				end
			end
			ST_COPY: begin
				if (sts.copy_done) begin
					state_next = ST_READ;
				end
			end
			ST_READ: begin
				state_next = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

`default_nettype wire

@@ hdl/ncap_datapath.sv @@
// Datapath of the NMEA sentence capture unit: line assembly, tag match,
// copy engine, sentence stores, flags and the output register.
// Depends on ncap_pkg and ncap_ram.
`default_nettype none

module ncap_datapath #(
	parameter int unsigned SENTENCE_BYTES = ncap_pkg::SENTENCE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ncap_pkg::in_item_t item,
	input  ncap_pkg::cmd_t     cmd,
	output ncap_pkg::sts_t     sts,
	output ncap_pkg::out_item_t result
);
	import ncap_pkg::*;

	localparam int unsigned POS_W = $clog2(SENTENCE_BYTES);
	localparam int unsigned CMP_W = (POS_W > 7) ? POS_W : 7;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(SENTENCE_BYTES - 1);

	// Line assembly state.
	logic             collecting_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       prefix_q [TAG_LEN];

	// Stored sentence lengths and update flags.
	logic [POS_W-1:0] gga_len_q;
	logic [POS_W-1:0] gll_len_q;
	logic             gga_flag_q;
	logic             gll_flag_q;

	// Copy engine.
	logic [POS_W-1:0] rd_cnt_q;
	logic [POS_W-1:0] wr_cnt_q;
	logic             rd_vld_q;
	logic             target_q;

	logic       item_sel_q;
	logic [6:0] item_idx_q;
	out_item_t  result_q;

	logic             is_byte;
	logic             is_dollar;
	logic             is_eol;
	logic             has_room;
	logic             hit_gga;
	logic             hit_gll;
	logic             lb_we;
	logic [POS_W-1:0] lb_waddr;
	logic [7:0]       lb_rdata;
	logic             store_we;
	logic [7:0]       gga_rdata;
	logic [7:0]       gll_rdata;
	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] len_ext;
	logic [7:0]       sel_rdata;

	assign is_byte   = cmd.take && (item.action == ACT_RX);
	assign is_dollar = (item.rx_byte == CH_DOLLAR);
	assign is_eol    = (item.rx_byte == CH_LF) || (item.rx_byte == CH_CR);
	assign has_room  = (pos_q < LAST_POS);

	always_comb begin
		hit_gga = (pos_q >= POS_W'(TAG_LEN));
		hit_gll = (pos_q >= POS_W'(TAG_LEN));
		for (int i = 0; i < TAG_LEN; i++) begin
			hit_gga &= (prefix_q[i] == GGA_TAG[8*(TAG_LEN-1-i) +: 8]);
			hit_gll &= (prefix_q[i] == GLL_TAG[8*(TAG_LEN-1-i) +: 8]);
		end
	end

	// Only a received byte can end a line; reads and clears never start a copy.
	assign sts.copy_start = (item.action == ACT_RX) && collecting_q && !is_dollar && is_eol &&
		(hit_gga || hit_gll);
	assign sts.copy_done  = cmd.copy && rd_vld_q && ((wr_cnt_q == pos_q) || (lb_rdata == CH_NUL));

	// A dollar always lands at position zero; other bytes append while there is room.
	assign lb_we    = is_byte && (is_dollar || (collecting_q && !is_eol && has_room));
	assign lb_waddr = is_dollar ? '0 : pos_q;
	assign store_we = cmd.copy && rd_vld_q && !sts.copy_done;

	ncap_ram #(.WIDTH(8), .DEPTH(SENTENCE_BYTES)) u_line_ram (
		.clk   (clk),
		.we    (lb_we),
		.waddr (lb_waddr),
		.wdata (item.rx_byte),
		.raddr (rd_cnt_q),
		.rdata (lb_rdata)
	);

	assign idx_ext = CMP_W'(item_idx_q);
	assign len_ext = (item_sel_q == SEL_GGA) ? CMP_W'(gga_len_q) : CMP_W'(gll_len_q);

	ncap_ram #(.WIDTH(8), .DEPTH(SENTENCE_BYTES)) u_gga_ram (
		.clk   (clk),
		.we    (store_we && (target_q == SEL_GGA)),
		.waddr (wr_cnt_q),
		.wdata (lb_rdata),
		.raddr (idx_ext[POS_W-1:0]),
		.rdata (gga_rdata)
	);

	ncap_ram #(.WIDTH(8), .DEPTH(SENTENCE_BYTES)) u_gll_ram (
		.clk   (clk),
		.we    (store_we && (target_q == SEL_GLL)),
		.waddr (wr_cnt_q),
		.wdata (lb_rdata),
		.raddr (idx_ext[POS_W-1:0]),
		.rdata (gll_rdata)
	);

	assign sel_rdata = (item_sel_q == SEL_GGA) ? gga_rdata : gll_rdata;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			pos_q        <= '0;
			gga_len_q    <= '0;
			gll_len_q    <= '0;
			gga_flag_q   <= 1'b0;
			gll_flag_q   <= 1'b0;
			rd_vld_q     <= 1'b0;
		end else begin
			if (is_byte) begin
				if (is_dollar) begin
					collecting_q <= 1'b1;
					pos_q        <= POS_W'(1);
				end else if (collecting_q) begin
					if (is_eol) begin
						collecting_q <= 1'b0;
					end else if (has_room) begin
						pos_q <= pos_q + POS_W'(1);
					end else begin
						collecting_q <= 1'b0;
					end
				end
			end
			if (cmd.take && (item.action == ACT_CLEAR)) begin
				if (item.which_sentence == SEL_GGA) begin
					gga_flag_q <= 1'b0;
				end else begin
					gll_flag_q <= 1'b0;
				end
			end
			if (cmd.take) begin
				rd_vld_q <= 1'b0;
			end else if (cmd.copy) begin
				rd_vld_q <= 1'b1;
			end
			if (sts.copy_done) begin
				if (target_q == SEL_GGA) begin
					gga_len_q  <= wr_cnt_q;
					gga_flag_q <= 1'b1;
				end else begin
					gll_len_q  <= wr_cnt_q;
					gll_flag_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (lb_we) begin
			for (int i = 0; i < TAG_LEN; i++) begin
				if (lb_waddr == POS_W'(i)) begin
					prefix_q[i] <= item.rx_byte;
				end
			end
		end
		if (cmd.take) begin
			item_sel_q <= item.which_sentence;
			item_idx_q <= item.read_index;
			target_q   <= hit_gga ? SEL_GGA : SEL_GLL;
			rd_cnt_q   <= '0;
			wr_cnt_q   <= '0;
		end else if (cmd.copy) begin
			rd_cnt_q <= rd_cnt_q + POS_W'(1);
			if (store_we) begin
				wr_cnt_q <= wr_cnt_q + POS_W'(1);
			end
		end
		if (cmd.load_out) begin
			result_q.read_byte   <= (idx_ext < len_ext) ? sel_rdata : CH_NUL;
			result_q.read_length <= len_ext[6:0];
			result_q.gga_updated <= gga_flag_q;
			result_q.gll_updated <= gll_flag_q;
		end
	end

	assign result = result_q;
endmodule

`default_nettype wire
